@@ rtl/core/mbd_pkg.sv @@
// Shared types, constants and sequencer codes for the moved block diagonal finder.
// No dependencies; every other source file except mbd_ram imports this package.
package mbd_pkg;

  localparam int MAX_LINES   = 1024;
  localparam int MAX_RESULTS = 64;

  localparam int LINE_AW    = $clog2(MAX_LINES);
  localparam int CNT_W      = LINE_AW + 1;
  localparam int HIST_DEPTH = 2 * MAX_LINES;
  localparam int HIST_AW    = LINE_AW + 1;
  localparam int DIST_W     = CNT_W + 1;
  localparam int RES_AW     = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int EMIT_W     = $clog2(MAX_RESULTS + 1);

  localparam int HASH_W = 64;
  localparam int NUM_W  = 24;
  localparam int FILE_W = 8;
  localparam int MAXF_W = 10;
  localparam int MINB_W = 11;
  localparam int GAP_W  = 10;
  localparam int CFG_W  = 11;
  localparam int RES_W  = 2 * LINE_AW + 2 * CNT_W + 2 * NUM_W;

  localparam logic [MAXF_W-1:0] MAXF_RST = MAXF_W'(30);
  localparam logic [MINB_W-1:0] MINB_RST = MINB_W'(5);
  localparam logic [GAP_W-1:0]  GAP_RST  = GAP_W'(3);

  typedef enum logic [1:0] {
    OP_LOAD_SRC = 2'd0,
    OP_LOAD_DST = 2'd1,
    OP_SEARCH   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_MAX_FREQ  = 2'd0,
    CFG_MIN_BLOCK = 2'd1,
    CFG_MAX_GAP   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [HASH_W-1:0] line_hash;
    logic [NUM_W-1:0]  line_number;
    logic [FILE_W-1:0] source_file;
    logic [FILE_W-1:0] dest_file;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [FILE_W-1:0]  src_file_out;
    logic [FILE_W-1:0]  dst_file_out;
    logic [LINE_AW-1:0] source_index;
    logic [LINE_AW-1:0] dest_index;
    logic [CNT_W-1:0]   block_size;
    logic [CNT_W-1:0]   matching_lines;
    logic [NUM_W-1:0]   source_line;
    logic [NUM_W-1:0]   dest_line;
    logic               last;
    logic               truncated;
    logic               lines_dropped;
  } out_item_t;

  // datapath micro-operations, one per cycle from the controller
  typedef enum logic [4:0] {
    U_NOP, U_ACCEPT, U_CLR, U_RDS, U_LATS, U_CNT_RD, U_CNT_CMP,
    U_INC_RD, U_INC_CMP, U_INC_WR, U_NEXT_I, U_H_RD, U_H_CHK, U_NEXT_DI,
    U_SCAN_RD, U_SCAN_CMP, U_G_START, U_EXT_RD, U_EXT_CMP, U_TT_RD,
    U_TT_CMP, U_TH_RD, U_TH_CMP, U_EVAL, U_NUM, U_STORE, U_O_RD,
    U_O_LOAD, U_O_NEXT, U_DONE
  } uop_e;

  typedef struct packed {
    logic is_search;
    logic nm_zero;
    logic clr_done;
    logic i_last;
    logic j_last;
    logic hash_eq;
    logic freq_ok;
    logic hist_ok;
    logic di_last;
    logic scan_eq;
    logic k_last;
    logic cur_lt_cnt;
    logic gap_ok;
    logic tail_ok;
    logic head_ok;
    logic step_gt1;
    logic len_ok;
    logic res_full;
    logic out_last;
  } sts_t;

endpackage

@@ rtl/core/mbd_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on mbd_pkg for the payload types.
interface mbd_in_if import mbd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mbd_out_if import mbd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/mbd_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mbd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                                wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [W-1:0]                                rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/mbd_datapath.sv @@
// Datapath: line stores, offset histogram, match list, result buffer and counters.
// Executes one micro-operation per cycle; depends on mbd_pkg and mbd_ram.
module mbd_datapath import mbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  in_item_t              in_data_i,
  input  uop_e                  uop_i,
  output sts_t                  sts_o,
  output out_item_t             out_data_o
);

  logic [MAXF_W-1:0]  maxf_q;
  logic [MINB_W-1:0]  minb_q;
  logic [GAP_W-1:0]   gap_q;
  logic [CNT_W-1:0]   n_q, m_q;
  logic               ovf_q;
  logic               trunc_q;
  logic [EMIT_W-1:0]  emit_q, oidx_q;
  logic [HIST_AW-1:0] a_q;
  logic [LINE_AW-1:0] i_q, j_q;
  logic [CNT_W-1:0]   c_q, di_q, k_q, cnt_q, cur_q, start_q;
  logic [HASH_W-1:0]  shash_q;
  logic [FILE_W-1:0]  sf_q, df_q;
  logic [LINE_AW-1:0] ki_q, kf_q;
  out_item_t          out_q;

  logic [HASH_W-1:0]  src_hash_rd, dst_hash_rd;
  logic [NUM_W-1:0]   src_num_rd, dst_num_rd;
  logic [CNT_W-1:0]   hist_rd;
  logic [LINE_AW-1:0] mpa_rd, mpb_rd;
  logic [RES_W-1:0]   res_rd;

  logic               load_src, load_dst;
  logic [HIST_AW-1:0] haddr;
  logic [DIST_W-1:0]  diag_ofs, kmax_w, m_minus;
  logic [CNT_W-1:0]   kmin, kmax;
  logic [LINE_AW-1:0] kd_addr, ad_addr, mpa_addr, mpb_addr;
  logic [LINE_AW-1:0] ab_diff;
  logic [CNT_W-1:0]   grp_len;
  logic               hist_we;
  logic [HIST_AW-1:0] hist_waddr, hist_raddr;
  logic [CNT_W-1:0]   hist_wdata;
  logic [RES_W-1:0]   res_wdata;
  logic [CNT_W-1:0]   bsize;

  assign load_src = (uop_i == U_ACCEPT) && (in_data_i.operation == OP_LOAD_SRC) &&
                    (n_q < CNT_W'(MAX_LINES));
  assign load_dst = (uop_i == U_ACCEPT) && (in_data_i.operation == OP_LOAD_DST) &&
                    (m_q < CNT_W'(MAX_LINES));

  // histogram slot of pair (i, j): j - i + n - 1
  assign haddr   = HIST_AW'(j_q) + HIST_AW'(n_q) - HIST_AW'(i_q) - HIST_AW'(1);

  assign diag_ofs = DIST_W'(di_q) - DIST_W'(n_q) + DIST_W'(1);
  assign kmin     = diag_ofs[DIST_W-1] ? CNT_W'(-diag_ofs) : '0;
  assign m_minus  = DIST_W'(m_q) - diag_ofs;
  assign kmax_w   = ($signed(m_minus) < $signed(DIST_W'(n_q))) ? m_minus : DIST_W'(n_q);
  assign kmax     = kmax_w[CNT_W-1:0];
  assign kd_addr  = LINE_AW'(DIST_W'(k_q) + diag_ofs);
  assign ad_addr  = LINE_AW'(DIST_W'(mpa_rd) + diag_ofs);

  assign ab_diff = mpa_rd - mpb_rd;
  assign grp_len = cur_q - start_q;
  assign bsize   = CNT_W'(kf_q - ki_q) + CNT_W'(1);

  always_comb begin
    mpa_addr = cur_q[LINE_AW-1:0];
    mpb_addr = LINE_AW'(cur_q - CNT_W'(1));
    case (uop_i)
      U_TT_RD: begin
        mpa_addr = LINE_AW'(cur_q - CNT_W'(1));
        mpb_addr = LINE_AW'(cur_q - CNT_W'(2));
      end
      U_TH_RD: begin
        mpa_addr = LINE_AW'(start_q + CNT_W'(1));
        mpb_addr = start_q[LINE_AW-1:0];
      end
      U_EVAL: begin
        mpa_addr = start_q[LINE_AW-1:0];
        mpb_addr = LINE_AW'(cur_q - CNT_W'(1));
      end
      default: ;
    endcase
  end

  assign hist_we    = (uop_i == U_CLR) || (uop_i == U_INC_WR);
  assign hist_waddr = (uop_i == U_CLR) ? a_q : haddr;
  assign hist_wdata = (uop_i == U_CLR) ? '0 : hist_rd + CNT_W'(1);
  assign hist_raddr = (uop_i == U_H_RD) ? di_q[HIST_AW-1:0] : haddr;

  assign res_wdata = {ki_q, LINE_AW'(DIST_W'(ki_q) + diag_ofs), bsize, grp_len,
                      src_num_rd, dst_num_rd};

  mbd_ram #(.W(HASH_W), .DEPTH(MAX_LINES)) u_src_hash (
    .clk_i, .we_i(load_src), .waddr_i(n_q[LINE_AW-1:0]), .wdata_i(in_data_i.line_hash),
    .raddr_i((uop_i == U_SCAN_RD) ? k_q[LINE_AW-1:0] : i_q), .rdata_o(src_hash_rd)
  );
  mbd_ram #(.W(NUM_W), .DEPTH(MAX_LINES)) u_src_num (
    .clk_i, .we_i(load_src), .waddr_i(n_q[LINE_AW-1:0]), .wdata_i(in_data_i.line_number),
    .raddr_i(mpa_rd), .rdata_o(src_num_rd)
  );
  mbd_ram #(.W(HASH_W), .DEPTH(MAX_LINES)) u_dst_hash (
    .clk_i, .we_i(load_dst), .waddr_i(m_q[LINE_AW-1:0]), .wdata_i(in_data_i.line_hash),
    .raddr_i((uop_i == U_SCAN_RD) ? kd_addr : j_q), .rdata_o(dst_hash_rd)
  );
  mbd_ram #(.W(NUM_W), .DEPTH(MAX_LINES)) u_dst_num (
    .clk_i, .we_i(load_dst), .waddr_i(m_q[LINE_AW-1:0]), .wdata_i(in_data_i.line_number),
    .raddr_i(ad_addr), .rdata_o(dst_num_rd)
  );
  mbd_ram #(.W(CNT_W), .DEPTH(HIST_DEPTH)) u_hist (
    .clk_i, .we_i(hist_we), .waddr_i(hist_waddr), .wdata_i(hist_wdata),
    .raddr_i(hist_raddr), .rdata_o(hist_rd)
  );
  // two copies of the match list give two reads per cycle
  mbd_ram #(.W(LINE_AW), .DEPTH(MAX_LINES)) u_mp_a (
    .clk_i, .we_i((uop_i == U_SCAN_CMP) && sts_o.scan_eq), .waddr_i(cnt_q[LINE_AW-1:0]),
    .wdata_i(k_q[LINE_AW-1:0]), .raddr_i(mpa_addr), .rdata_o(mpa_rd)
  );
  mbd_ram #(.W(LINE_AW), .DEPTH(MAX_LINES)) u_mp_b (
    .clk_i, .we_i((uop_i == U_SCAN_CMP) && sts_o.scan_eq), .waddr_i(cnt_q[LINE_AW-1:0]),
    .wdata_i(k_q[LINE_AW-1:0]), .raddr_i(mpb_addr), .rdata_o(mpb_rd)
  );
  mbd_ram #(.W(RES_W), .DEPTH(MAX_RESULTS)) u_res (
    .clk_i, .we_i(uop_i == U_STORE), .waddr_i(emit_q[RES_AW-1:0]), .wdata_i(res_wdata),
    .raddr_i(oidx_q[RES_AW-1:0]), .rdata_o(res_rd)
  );

  always_comb begin
    sts_o            = '0;
    sts_o.is_search  = (in_data_i.operation == OP_SEARCH);
    sts_o.nm_zero    = (n_q == '0) || (m_q == '0);
    sts_o.clr_done   = (a_q == HIST_AW'(HIST_DEPTH - 1));
    sts_o.i_last     = (CNT_W'(i_q) == n_q - CNT_W'(1));
    sts_o.j_last     = (CNT_W'(j_q) == m_q - CNT_W'(1));
    sts_o.hash_eq    = (shash_q == dst_hash_rd);
    sts_o.freq_ok    = (c_q != '0) && (32'(c_q) <= 32'(maxf_q));
    sts_o.hist_ok    = (32'(hist_rd) >= 32'(minb_q));
    sts_o.di_last    = (di_q == n_q + m_q - CNT_W'(2));
    sts_o.scan_eq    = (src_hash_rd == dst_hash_rd);
    sts_o.k_last     = (k_q == kmax - CNT_W'(1));
    sts_o.cur_lt_cnt = (cur_q < cnt_q);
    sts_o.gap_ok     = (32'(ab_diff - LINE_AW'(1)) <= 32'(gap_q));
    sts_o.tail_ok    = (cur_q > start_q + CNT_W'(1));
    sts_o.head_ok    = (start_q + CNT_W'(1) < cur_q);
    sts_o.step_gt1   = (ab_diff > LINE_AW'(1));
    sts_o.len_ok     = (32'(grp_len) >= 32'(minb_q));
    sts_o.res_full   = (emit_q == EMIT_W'(MAX_RESULTS));
    sts_o.out_last   = out_q.last;
  end

  // control state: counts, flags, config, loop indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxf_q  <= MAXF_RST;
      minb_q  <= MINB_RST;
      gap_q   <= GAP_RST;
      n_q     <= '0;
      m_q     <= '0;
      ovf_q   <= 1'b0;
      trunc_q <= 1'b0;
      emit_q  <= '0;
      oidx_q  <= '0;
      a_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      c_q     <= '0;
      di_q    <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      cur_q   <= '0;
      start_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_FREQ:  maxf_q <= cfg_data_i[MAXF_W-1:0];
          CFG_MIN_BLOCK: minb_q <= cfg_data_i[MINB_W-1:0];
          CFG_MAX_GAP:   gap_q  <= cfg_data_i[GAP_W-1:0];
          default: ;
        endcase
      end
      case (uop_i)
        U_ACCEPT: begin
          if (load_src) n_q <= n_q + CNT_W'(1);
          if (load_dst) m_q <= m_q + CNT_W'(1);
          if (((in_data_i.operation == OP_LOAD_SRC) && !load_src) ||
              ((in_data_i.operation == OP_LOAD_DST) && !load_dst)) begin
            ovf_q <= 1'b1;
          end
          a_q     <= '0;
          i_q     <= '0;
          di_q    <= '0;
          emit_q  <= '0;
          oidx_q  <= '0;
          trunc_q <= 1'b0;
        end
        U_CLR:     a_q <= a_q + HIST_AW'(1);
        U_LATS: begin
          j_q <= '0;
          c_q <= '0;
        end
        U_CNT_CMP: begin
          if (sts_o.hash_eq) c_q <= c_q + CNT_W'(1);
          j_q <= sts_o.j_last ? '0 : j_q + LINE_AW'(1);
        end
        U_INC_CMP: if (!sts_o.hash_eq) j_q <= sts_o.j_last ? '0 : j_q + LINE_AW'(1);
        U_INC_WR:  j_q <= sts_o.j_last ? '0 : j_q + LINE_AW'(1);
        U_NEXT_I:  i_q <= i_q + LINE_AW'(1);
        U_H_CHK: begin
          k_q   <= kmin;
          cnt_q <= '0;
        end
        U_NEXT_DI: di_q <= di_q + CNT_W'(1);
        U_SCAN_CMP: begin
          if (sts_o.scan_eq) cnt_q <= cnt_q + CNT_W'(1);
          k_q   <= k_q + CNT_W'(1);
          cur_q <= '0;
        end
        U_G_START: begin
          start_q <= cur_q;
          cur_q   <= cur_q + CNT_W'(1);
        end
        U_EXT_CMP: if (sts_o.gap_ok) cur_q <= cur_q + CNT_W'(1);
        U_TT_CMP:  if (sts_o.step_gt1) cur_q <= cur_q - CNT_W'(1);
        U_TH_CMP:  if (sts_o.step_gt1) start_q <= start_q + CNT_W'(1);
        U_EVAL:    if (sts_o.len_ok && sts_o.res_full) trunc_q <= 1'b1;
        U_STORE:   emit_q <= emit_q + EMIT_W'(1);
        U_O_NEXT:  oidx_q <= oidx_q + EMIT_W'(1);
        U_DONE: begin
          n_q   <= '0;
          m_q   <= '0;
          ovf_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if ((uop_i == U_ACCEPT) && sts_o.is_search) begin
      sf_q <= in_data_i.source_file;
      df_q <= in_data_i.dest_file;
    end
    if (uop_i == U_LATS) shash_q <= src_hash_rd;
    if (uop_i == U_NUM) begin
      ki_q <= mpa_rd;
      kf_q <= mpb_rd;
    end
    if (uop_i == U_O_LOAD) begin
      out_q.src_file_out  <= sf_q;
      out_q.dst_file_out  <= df_q;
      out_q.truncated     <= trunc_q;
      out_q.lines_dropped <= ovf_q;
      if (emit_q == '0) begin
        out_q.found          <= 1'b0;
        out_q.source_index   <= '0;
        out_q.dest_index     <= '0;
        out_q.block_size     <= '0;
        out_q.matching_lines <= '0;
        out_q.source_line    <= '0;
        out_q.dest_line      <= '0;
        out_q.last           <= 1'b1;
      end else begin
        out_q.found <= 1'b1;
        {out_q.source_index, out_q.dest_index, out_q.block_size, out_q.matching_lines,
         out_q.source_line, out_q.dest_line} <= res_rd;
        out_q.last  <= (oidx_q + EMIT_W'(1) == emit_q);
      end
    end
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/core/mbd_ctrl.sv @@
// Controller: sequences loads, histogram build, diagonal scan, grouping and output.
// Depends on mbd_pkg; drives micro-operations into mbd_datapath.
module mbd_ctrl import mbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output uop_e uop_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_RDS, S_LATS, S_CNT_RD, S_CNT_CMP, S_FREQ, S_INC_RD, S_INC_CMP,
    S_INC_WR, S_ENDI, S_NEXT_I, S_H_RD, S_H_CHK, S_NEXT_DI, S_SCAN_RD, S_SCAN_CMP,
    S_G_START, S_EXT_RD, S_EXT_CMP, S_TT_RD, S_TT_CMP, S_TH_RD, S_TH_CMP, S_EVAL,
    S_NUM, S_STORE, S_O_RD, S_O_LOAD, S_O_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   in_fire, out_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_O_WAIT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    uop_o   = U_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          uop_o = U_ACCEPT;
          if (sts_i.is_search) state_d = sts_i.nm_zero ? S_O_RD : S_CLR;
        end
      end
      S_CLR: begin
        uop_o = U_CLR;
        if (sts_i.clr_done) state_d = S_RDS;
      end
      S_RDS: begin
        uop_o   = U_RDS;
        state_d = S_LATS;
      end
      S_LATS: begin
        uop_o   = U_LATS;
        state_d = S_CNT_RD;
      end
      S_CNT_RD: begin
        uop_o   = U_CNT_RD;
        state_d = S_CNT_CMP;
      end
      S_CNT_CMP: begin
        uop_o   = U_CNT_CMP;
        state_d = sts_i.j_last ? S_FREQ : S_CNT_RD;
      end
      S_FREQ:    state_d = sts_i.freq_ok ? S_INC_RD : S_ENDI;
      S_INC_RD: begin
        uop_o   = U_INC_RD;
        state_d = S_INC_CMP;
      end
      S_INC_CMP: begin
        uop_o = U_INC_CMP;
        if (sts_i.hash_eq) state_d = S_INC_WR;
        else               state_d = sts_i.j_last ? S_ENDI : S_INC_RD;
      end
      S_INC_WR: begin
        uop_o   = U_INC_WR;
        state_d = sts_i.j_last ? S_ENDI : S_INC_RD;
      end
      S_ENDI:    state_d = sts_i.i_last ? S_H_RD : S_NEXT_I;
      S_NEXT_I: begin
        uop_o   = U_NEXT_I;
        state_d = S_RDS;
      end
      S_H_RD: begin
        uop_o   = U_H_RD;
        state_d = S_H_CHK;
      end
      S_H_CHK: begin
        uop_o = U_H_CHK;
        if (sts_i.hist_ok) state_d = S_SCAN_RD;
        else               state_d = sts_i.di_last ? S_O_RD : S_NEXT_DI;
      end
      S_NEXT_DI: begin
        uop_o   = U_NEXT_DI;
        state_d = S_H_RD;
      end
      S_SCAN_RD: begin
        uop_o   = U_SCAN_RD;
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        uop_o   = U_SCAN_CMP;
        state_d = sts_i.k_last ? S_G_START : S_SCAN_RD;
      end
      S_G_START: begin
        if (sts_i.cur_lt_cnt) begin
          uop_o   = U_G_START;
          state_d = S_EXT_RD;
        end else begin
          state_d = sts_i.di_last ? S_O_RD : S_NEXT_DI;
        end
      end
      // grow the group while the gap to the previous match is tolerated
      S_EXT_RD: begin
        uop_o   = U_EXT_RD;
        state_d = sts_i.cur_lt_cnt ? S_EXT_CMP : S_TT_RD;
      end
      S_EXT_CMP: begin
        uop_o   = U_EXT_CMP;
        state_d = sts_i.gap_ok ? S_EXT_RD : S_TT_RD;
      end
      // trim non-adjacent matches off the tail, then the head
      S_TT_RD: begin
        uop_o   = U_TT_RD;
        state_d = sts_i.tail_ok ? S_TT_CMP : S_TH_RD;
      end
      S_TT_CMP: begin
        uop_o   = U_TT_CMP;
        state_d = sts_i.step_gt1 ? S_TT_RD : S_TH_RD;
      end
      S_TH_RD: begin
        uop_o   = U_TH_RD;
        state_d = sts_i.head_ok ? S_TH_CMP : S_EVAL;
      end
      S_TH_CMP: begin
        uop_o   = U_TH_CMP;
        state_d = sts_i.step_gt1 ? S_TH_RD : S_EVAL;
      end
      S_EVAL: begin
        uop_o   = U_EVAL;
        state_d = (sts_i.len_ok && !sts_i.res_full) ? S_NUM : S_G_START;
      end
      S_NUM: begin
        uop_o   = U_NUM;
        state_d = S_STORE;
      end
      S_STORE: begin
        uop_o   = U_STORE;
        state_d = S_G_START;
      end
      S_O_RD: begin
        uop_o   = U_O_RD;
        state_d = S_O_LOAD;
      end
      S_O_LOAD: begin
        uop_o   = U_O_LOAD;
        state_d = S_O_WAIT;
      end
      S_O_WAIT: begin
        if (out_fire) begin
          if (sts_i.out_last) begin
            uop_o   = U_DONE;
            state_d = S_IDLE;
          end else begin
            uop_o   = U_O_NEXT;
            state_d = S_O_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/moved_block_diagonal_finder.sv @@
// Moved block diagonal finder. Loads are accepted one per cycle. A search clears the
// histogram, counts each source line's matches in the destination, adds its matched
// pairs when its frequency passes, checks every offset, scans each hot diagonal,
// groups its matches and sends the result beats; input is held off throughout.
// Reset (rst_ni low, async) clears line counts, flags and config to defaults.
// Depends on mbd_pkg, mbd_if, mbd_ctrl and mbd_datapath.
module moved_block_diagonal_finder import mbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  mbd_in_if.sink           in_chan,
  mbd_out_if.source        out_chan
);

  uop_e uop;
  sts_t sts;

  mbd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_chan.ready),
    .out_valid_o(out_chan.valid),
    .out_ready_i(out_chan.ready),
    .sts_i      (sts),
    .uop_o      (uop)
  );

  mbd_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_data_i (in_chan.data),
    .uop_i     (uop),
    .sts_o     (sts),
    .out_data_o(out_chan.data)
  );

endmodule

@@ rtl/core/mbd_checker.sv @@
// Port-level checks for the moved block diagonal finder, bound to the top level.
// Depends on mbd_pkg.
module mbd_checker import mbd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("input ready while results pending");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.found |-> out_data.last && (out_data.block_size == '0) &&
    (out_data.matching_lines == '0) && (out_data.source_index == '0))
    else $error("empty search result malformed");

  a_block_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.found |-> (out_data.matching_lines != '0) &&
    (out_data.matching_lines <= out_data.block_size))
    else $error("block has more matches than lines");

endmodule

bind moved_block_diagonal_finder mbd_checker u_mbd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_ready (in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_data (out_chan.data)
);

@@ verif/moved_block_diagonal_finder_tb.sv @@
// Self-checking testbench for moved_block_diagonal_finder: load/search stimulus,
// a diagonal-search predictor held in a scoreboard, random handshake stalls.
// Depends on mbd_pkg, mbd_if and the RTL of the block.
`timescale 1ns / 100ps

module moved_block_diagonal_finder_tb;
  import mbd_pkg::*;

  // operation code the block ignores
  localparam logic [1:0] OP_RESERVED = 2'd3;

  class block_scoreboard;
    logic [HASH_W-1:0] src_hash [MAX_LINES];
    logic [NUM_W-1:0]  src_num  [MAX_LINES];
    logic [HASH_W-1:0] dst_hash [MAX_LINES];
    logic [NUM_W-1:0]  dst_num  [MAX_LINES];
    int                src_cnt, dst_cnt;
    bit                dropped;
    int                max_freq, min_blk, gap_tol;
    out_item_t         pending_beats[$];
    int                errors;

    function new();
      src_cnt  = 0;
      dst_cnt  = 0;
      dropped  = 0;
      max_freq = 30;
      min_blk  = 5;
      gap_tol  = 3;
      errors   = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, int value);
      case (idx)
        CFG_MAX_FREQ:  max_freq = value & 'h3ff;
        CFG_MIN_BLOCK: min_blk  = value & 'h7ff;
        CFG_MAX_GAP:   gap_tol  = value & 'h3ff;
        default: ;
      endcase
    endfunction

    function void note_input(in_item_t it);
      if (it.operation == OP_LOAD_SRC) begin
        if (src_cnt < MAX_LINES) begin
          src_hash[src_cnt] = it.line_hash;
          src_num[src_cnt]  = it.line_number;
          src_cnt++;
        end else dropped = 1;
      end else if (it.operation == OP_LOAD_DST) begin
        if (dst_cnt < MAX_LINES) begin
          dst_hash[dst_cnt] = it.line_hash;
          dst_num[dst_cnt]  = it.line_number;
          dst_cnt++;
        end else dropped = 1;
      end else if (it.operation == OP_SEARCH) begin
        find_blocks(it.source_file, it.dest_file);
      end
    endfunction

    function void find_blocks(logic [FILE_W-1:0] sf, logic [FILE_W-1:0] df);
      int        hist [2*MAX_LINES];
      int        pos [MAX_LINES];
      out_item_t blocks[$];
      out_item_t r;
      int        n, m, c, diag_ofs, kmin, kmax, cnt, cur, start;
      bit        trunc;
      n = src_cnt;
      m = dst_cnt;
      trunc = 0;
      foreach (hist[x]) hist[x] = 0;
      if (n > 0 && m > 0) begin
        for (int i = 0; i < n; i++) begin
          c = 0;
          for (int j = 0; j < m; j++) if (dst_hash[j] == src_hash[i]) c++;
          if (c == 0 || c > max_freq) continue;
          for (int j = 0; j < m; j++)
            if (dst_hash[j] == src_hash[i]) hist[j - i + n - 1]++;
        end
        for (int d = 0; d <= n + m - 2; d++) begin
          if (hist[d] < min_blk) continue;
          diag_ofs = d - (n - 1);
          kmin = diag_ofs < 0 ? -diag_ofs : 0;
          kmax = (m - diag_ofs < n) ? m - diag_ofs : n;
          if (kmax <= kmin) continue;
          cnt = 0;
          for (int k = kmin; k < kmax; k++)
            if (src_hash[k] == dst_hash[k + diag_ofs]) begin
              pos[cnt] = k;
              cnt++;
            end
          cur = 0;
          while (cur < cnt) begin
            start = cur;
            cur++;
            while (cur < cnt && pos[cur] - pos[cur-1] - 1 <= gap_tol) cur++;
            // drop non-adjacent matches off the tail; they open the next group
            while (cur > start + 1 && pos[cur-1] - pos[cur-2] > 1) cur--;
            while (start + 1 < cur && pos[start+1] - pos[start] > 1) start++;
            if (cur - start < min_blk) continue;
            if (blocks.size() >= MAX_RESULTS) begin
              trunc = 1;
              continue;
            end
            r = '0;
            r.found          = 1;
            r.src_file_out   = sf;
            r.dst_file_out   = df;
            r.source_index   = LINE_AW'(pos[start]);
            r.dest_index     = LINE_AW'(pos[start] + diag_ofs);
            r.block_size     = CNT_W'(pos[cur-1] - pos[start] + 1);
            r.matching_lines = CNT_W'(cur - start);
            r.source_line    = src_num[pos[start]];
            r.dest_line      = dst_num[pos[start] + diag_ofs];
            blocks.push_back(r);
          end
        end
      end
      if (blocks.size() == 0) begin
        r = '0;
        r.src_file_out = sf;
        r.dst_file_out = df;
        blocks.push_back(r);
      end
      foreach (blocks[x]) begin
        blocks[x].truncated     = trunc;
        blocks[x].lines_dropped = dropped;
        blocks[x].last          = (x == blocks.size() - 1);
        pending_beats.push_back(blocks[x]);
      end
      src_cnt = 0;
      dst_cnt = 0;
      dropped = 0;
    endfunction

    function void cmp(string fname, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", fname, e, a);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
        return;
      end
      e = pending_beats.pop_front();
      cmp("found", e.found, got.found);
      cmp("src_file_out", e.src_file_out, got.src_file_out);
      cmp("dst_file_out", e.dst_file_out, got.dst_file_out);
      cmp("source_index", e.source_index, got.source_index);
      cmp("dest_index", e.dest_index, got.dest_index);
      cmp("block_size", e.block_size, got.block_size);
      cmp("matching_lines", e.matching_lines, got.matching_lines);
      cmp("source_line", e.source_line, got.source_line);
      cmp("dest_line", e.dest_line, got.dest_line);
      cmp("last", e.last, got.last);
      cmp("truncated", e.truncated, got.truncated);
      cmp("lines_dropped", e.lines_dropped, got.lines_dropped);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  mbd_in_if  in_chan ();
  mbd_out_if out_chan ();

  moved_block_diagonal_finder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_chan    (in_chan.sink),
    .out_chan   (out_chan.source)
  );

  block_scoreboard sb = new();
  int  tx_idle_pct, rx_idle_pct;
  int  items_sent;
  bit  hold_req;
  int  hold_left;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 0;
      out_chan.ready <= 1'b0;
      hold_left <= 3000;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_chan.valid && out_chan.ready) sb.check_result(out_chan.data);

  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= it;
    do @(posedge clk_i); while (!in_chan.ready);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic stop_sending();
    in_chan.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    stop_sending();
    while (sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic set_regs(int mf, int mb, int mg);
    write_reg(CFG_MAX_FREQ, mf);
    write_reg(CFG_MIN_BLOCK, mb);
    write_reg(CFG_MAX_GAP, mg);
  endtask

  function automatic in_item_t line_beat(op_e op, logic [HASH_W-1:0] h);
    in_item_t it;
    it.operation   = op;
    it.line_hash   = h;
    it.line_number = ($urandom_range(9) == 0) ? {NUM_W{1'b1}} : NUM_W'($urandom);
    it.source_file = FILE_W'($urandom);
    it.dest_file   = FILE_W'($urandom);
    return it;
  endfunction

  task automatic search(logic [FILE_W-1:0] sf, logic [FILE_W-1:0] df);
    in_item_t it;
    it = line_beat(OP_SEARCH, {$urandom, $urandom});
    it.source_file = sf;
    it.dest_file   = df;
    send_item(it);
  endtask

  // source text, then a destination that reuses runs of it with inserted lines
  task automatic moved_text_case(int n, int m, bit noisy);
    logic [HASH_W-1:0] pool [8];
    logic [HASH_W-1:0] src [$];
    logic [HASH_W-1:0] dst [$];
    int                npool, s, run, is, id;
    in_item_t          it;
    npool = $urandom_range(1, 8);
    foreach (pool[x]) pool[x] = {$urandom, $urandom};
    pool[0] = ($urandom_range(1)) ? '0 : '1;
    for (int i = 0; i < n; i++) src.push_back(pool[$urandom_range(npool - 1)]);
    while (dst.size() < m) begin
      if ($urandom_range(2) != 0) begin
        s   = $urandom_range(n - 1);
        run = $urandom_range(1, 10);
        for (int k = s; k < n && k < s + run && dst.size() < m; k++) dst.push_back(src[k]);
      end else begin
        dst.push_back(($urandom_range(1)) ? pool[$urandom_range(npool - 1)]
                                          : {$urandom, $urandom});
      end
    end
    is = 0;
    id = 0;
    while (is < n || id < m) begin
      if (noisy && $urandom_range(15) == 0) begin
        it = line_beat(OP_LOAD_SRC, {$urandom, $urandom});
        it.operation = OP_RESERVED;
        send_item(it);
      end
      if (id >= m || (is < n && $urandom_range(1))) send_item(line_beat(OP_LOAD_SRC, src[is++]));
      else send_item(line_beat(OP_LOAD_DST, dst[id++]));
    end
    if (noisy && $urandom_range(7) == 0) search(FILE_W'($urandom), FILE_W'($urandom));
    search(FILE_W'($urandom), FILE_W'($urandom));
  endtask

  task automatic random_part(int until_items);
    while (items_sent < until_items) begin
      if (items_sent < 110)      begin tx_idle_pct = 12; rx_idle_pct = 59; end
      else if (items_sent < 200) begin tx_idle_pct = 59; rx_idle_pct = 12; end
      else                       begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      moved_text_case($urandom_range(1, 24), $urandom_range(1, 24), 1);
    end
  endtask

  initial begin
    in_item_t it;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_MAX_FREQ;
    cfg_data_i     = '0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    hold_req       = 0;
    hold_left      = 0;
    items_sent     = 0;
    tx_idle_pct    = 12;
    rx_idle_pct    = 59;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty search, unused opcode, extreme values, reset settings
    search(8'h00, 8'hff);
    it = line_beat(OP_LOAD_DST, '1);
    it.operation = OP_RESERVED;
    send_item(it);
    for (int i = 0; i < 6; i++) begin
      it = line_beat(OP_LOAD_SRC, (i % 2) ? '1 : '0);
      it.line_number = (i % 2) ? {NUM_W{1'b1}} : '0;
      send_item(it);
      it.operation = OP_LOAD_DST;
      send_item(it);
    end
    search(8'hff, 8'h00);

    // one match per group on every diagonal: far more than the result limit
    set_regs(1023, 1, 0);
    for (int i = 0; i < 20; i++) send_item(line_beat(OP_LOAD_SRC, 64'h1));
    for (int i = 0; i < 20; i++) send_item(line_beat(OP_LOAD_DST, (i % 2) ? 64'h2 : 64'h1));
    search(8'h11, 8'h22);

    // random part across several register settings
    set_regs(30, 5, 3);
    random_part(110);
    set_regs(1, 1024, 1023);
    random_part(140);
    set_regs(2, 2, 1);
    // long receiver hold-off while searches keep coming
    hold_req = 1;
    random_part(170);
    drain();
    set_regs(1023, 3, 0);
    random_part(200);
    set_regs(5, 1, 2);
    random_part(230);
    set_regs(30, 4, 6);
    random_part(260);

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/mbd_pkg.sv
rtl/core/mbd_if.sv
rtl/core/mbd_ram.sv
rtl/core/mbd_datapath.sv
rtl/core/mbd_ctrl.sv
rtl/core/moved_block_diagonal_finder.sv
rtl/core/mbd_checker.sv
verif/moved_block_diagonal_finder_tb.sv
